### hdl/prgb_pkg.sv
// Shared types and constants for the packed pixel to 16-bit RGBA converter.
package prgb_pkg;

  // Pixel format codes
  localparam logic [1:0] FMT_A2B10G10R10 = 2'd0;
  localparam logic [1:0] FMT_RGB565_LE   = 2'd1;
  localparam logic [1:0] FMT_RGB565_BE   = 2'd2;
  // Bit of the format code that selects the byte swap
  localparam int FMT_SWAP_BIT = 1;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_PIXEL_FORMAT  = 3'd0,
    REG_SCALE_RED     = 3'd1,
    REG_SCALE_GREEN   = 3'd2,
    REG_SCALE_BLUE    = 3'd3,
    REG_SCALE_ALPHA   = 3'd4,
    REG_INVERT_MASK   = 3'd5,
    REG_LIMITED_RANGE = 3'd6
  } cfg_reg_e;

  localparam int CFG_DATA_W = 10;
  localparam int SCALE_W    = 10;
  localparam int CHAN_W     = 16;

  localparam logic [CHAN_W-1:0] FULL_MAX    = 16'hFFFF;
  localparam logic [CHAN_W-1:0] LIMITED_MIN = 16'd4096;
  localparam logic [CHAN_W-1:0] LIMITED_MAX = 16'd60160;

  // Invert mask bit positions
  localparam int INV_RED   = 0;
  localparam int INV_GREEN = 1;
  localparam int INV_BLUE  = 2;
  localparam int INV_ALPHA = 3;

  // One input item
  typedef struct packed {
    logic [31:0] pixel_word;
    logic        frame_end;
  } pixel_in_t;

  // One result item
  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
    logic              frame_end_out;
  } pixel_out_t;

  // Load enables of a two-register datapath section
  typedef struct packed {
    logic first;
    logic second;
  } pair_en_t;

endpackage

### hdl/prgb_unpack.sv
// Unpack stage: splits the pixel word and widens each channel to 16 bits.
module prgb_unpack
  import prgb_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       pixel_word,
  input  logic [1:0]        pixel_format,
  output logic [CHAN_W-1:0] red,
  output logic [CHAN_W-1:0] green,
  output logic [CHAN_W-1:0] blue,
  output logic [CHAN_W-1:0] alpha,
  output logic              alpha_fixed
);

  // floor(v * 65535 / 31) = v * 2114, plus one when v is full scale
  function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
    logic [CHAN_W-1:0] base;
    base = CHAN_W'(v) * 16'd2114;
    return base + CHAN_W'(v == 5'h1F);
  endfunction

  // floor(v * 65535 / 63) = v * 1040 + floor(15v / 63); the last term is
  // floor(5v / 21), taken as a reciprocal multiply that is exact for 6-bit v
  function automatic logic [CHAN_W-1:0] widen6(input logic [5:0] v);
    logic [8:0]  x;
    logic [19:0] p;
    x = 9'(v) * 9'd5;
    p = 20'(x) * 20'd3121;
    return CHAN_W'(v) * 16'd1040 + CHAN_W'(p[19:16]);
  endfunction

  logic [15:0] half;
  logic [1:0]  a2;

  always_comb begin
    half = pixel_word[15:0];
    if (pixel_format[FMT_SWAP_BIT]) begin
      half = {pixel_word[7:0], pixel_word[15:8]};
    end
    a2 = pixel_word[31:30];
  end

  // Register the widened channels
  always_ff @(posedge clk) begin
    if (en) begin
      if (pixel_format == FMT_A2B10G10R10) begin
        red         <= {pixel_word[9:0], 6'd0};
        green       <= {pixel_word[19:10], 6'd0};
        blue        <= {pixel_word[29:20], 6'd0};
        alpha       <= {8{a2}};
        alpha_fixed <= 1'b0;
      end else begin
        red         <= widen5(half[15:11]);
        green       <= widen6(half[10:5]);
        blue        <= widen5(half[4:0]);
        alpha       <= FULL_MAX;
        alpha_fixed <= 1'b1;
      end
    end
  end

endmodule

### hdl/prgb_scale.sv
// Scale section: multiply by the channel scale, then clip and invert.
module prgb_scale
  import prgb_pkg::*;
(
  input  logic               clk,
  input  pair_en_t           en,
  input  logic [CHAN_W-1:0]  value,
  input  logic [SCALE_W-1:0] scale,
  input  logic               invert,
  output logic [CHAN_W-1:0]  result
);

  localparam int PROD_W = CHAN_W + SCALE_W;

  logic [PROD_W-1:0] prod;
  logic [CHAN_W-1:0] clipped;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (en.first) begin
      prod <= PROD_W'(value) * PROD_W'(scale);
    end
  end

  // Clip to the 16-bit range
  always_comb begin
    clipped = prod[CHAN_W-1:0];
    if (|prod[PROD_W-1:CHAN_W]) begin
      clipped = FULL_MAX;
    end
  end

  // Invert stage
  always_ff @(posedge clk) begin
    if (en.second) begin
      result <= invert ? (FULL_MAX - clipped) : clipped;
    end
  end

endmodule

### hdl/prgb_expand.sv
// Range expansion section: maps 4096..60160 onto 0..65535 with floor.
module prgb_expand
  import prgb_pkg::*;
(
  input  logic              clk,
  input  pair_en_t          en,
  input  logic [CHAN_W-1:0] value,
  input  logic              limited,
  output logic [CHAN_W-1:0] result
);

  // ceil(65535 * 2^32 / 56064); the rounding error stays below one step
  // of the true quotient, so the floor of the product is exact
  localparam int RECIP_W = 33;
  localparam logic [63:0] RECIP_WIDE =
    (64'd65535 * 64'd4294967296 + 64'd56063) / 64'd56064;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_WIDE);
  localparam int PROD_W = CHAN_W + RECIP_W;

  logic [CHAN_W-1:0] diff;
  logic [PROD_W-1:0] prod;
  logic [CHAN_W-1:0] quot;
  logic [CHAN_W-1:0] raw;
  logic              at_low;
  logic              at_high;

  assign diff = value - LIMITED_MIN;

  // Multiply stage; keep the bounds and the unexpanded value alongside
  always_ff @(posedge clk) begin
    if (en.first) begin
      prod    <= PROD_W'(diff) * PROD_W'(RECIP);
      raw     <= value;
      at_low  <= (value <= LIMITED_MIN);
      at_high <= (value >= LIMITED_MAX);
    end
  end

  assign quot = prod[32 +: CHAN_W];

  // Select stage
  always_ff @(posedge clk) begin
    if (en.second) begin
      if (!limited) begin
        result <= raw;
      end else if (at_low) begin
        result <= '0;
      end else if (at_high) begin
        result <= FULL_MAX;
      end else begin
        result <= quot;
      end
    end
  end

endmodule

### hdl/packed_rgb_to_rgba16_converter_unit.sv
// Top level of the packed pixel to 16-bit RGBA converter.
//
// Input channel in_valid/in_ready/in_data carries one packed pixel word and
// a frame-end mark per item; the word is read as A2B10G10R10 or RGB565
// (little or big endian) as the pixel_format register selects.
// Output channel out_valid/out_ready/out_data gives 16-bit red, green, blue,
// alpha and the frame-end mark, one result per item, in order.
// Registers are written through cfg_write/cfg_index/cfg_data, one per cycle;
// the user must write only while no item is in flight (the block does not enforce it).
// The datapath is a five-stage pipeline: unpack, scale multiply,
// clip/invert, range-expansion multiply, select. An accepted item is
// registered into each stage in that order and its result is offered from
// the select stage; one item per cycle is sustained while out_ready stays
// high.
// Reset clears all stage valid bits and loads register defaults (format
// A2B10G10R10, scales 1, no inversion, full range).
// When the receiver holds out_ready low, the result stays in the output
// stage and earlier stages keep filling; in_ready drops only once all five
// stages hold an item.
module packed_rgb_to_rgba16_converter_unit
  import prgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pixel_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pixel_out_t            out_data,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int STAGES = 5;

  // Configuration registers
  logic [1:0]         pixel_format;
  logic [SCALE_W-1:0] scale_red;
  logic [SCALE_W-1:0] scale_green;
  logic [SCALE_W-1:0] scale_blue;
  logic [SCALE_W-1:0] scale_alpha;
  logic [3:0]         invert_mask;
  logic               limited_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format  <= FMT_A2B10G10R10;
      scale_red     <= SCALE_W'(1);
      scale_green   <= SCALE_W'(1);
      scale_blue    <= SCALE_W'(1);
      scale_alpha   <= SCALE_W'(1);
      invert_mask   <= '0;
      limited_range <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_PIXEL_FORMAT:  pixel_format  <= cfg_data[1:0];
        REG_SCALE_RED:     scale_red     <= cfg_data;
        REG_SCALE_GREEN:   scale_green   <= cfg_data;
        REG_SCALE_BLUE:    scale_blue    <= cfg_data;
        REG_SCALE_ALPHA:   scale_alpha   <= cfg_data;
        REG_INVERT_MASK:   invert_mask   <= cfg_data[3:0];
        REG_LIMITED_RANGE: limited_range <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its item moves on
  logic [STAGES-1:0] valid;
  logic [STAGES:0]   en;

  always_comb begin
    en[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid[STAGES-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // Frame-end mark travels with the item
  logic [STAGES-1:0] frame_end;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      frame_end[0] <= in_data.frame_end;
    end
    for (int i = 1; i < STAGES; i++) begin
      if (en[i]) begin
        frame_end[i] <= frame_end[i-1];
      end
    end
  end

  // Stage 1: unpack
  logic [CHAN_W-1:0] red1, green1, blue1, alpha1;
  logic              fixed1;

  prgb_unpack u_unpack (
    .clk         (clk),
    .en          (en[0]),
    .pixel_word  (in_data.pixel_word),
    .pixel_format(pixel_format),
    .red         (red1),
    .green       (green1),
    .blue        (blue1),
    .alpha       (alpha1),
    .alpha_fixed (fixed1)
  );

  // Stages 2 and 3: scale, clip, invert
  pair_en_t          scale_en;
  logic [CHAN_W-1:0] red3, green3, blue3, alpha3;

  assign scale_en = '{first: en[1], second: en[2]};

  prgb_scale u_scale_red (
    .clk(clk), .en(scale_en), .value(red1), .scale(scale_red),
    .invert(invert_mask[INV_RED]), .result(red3)
  );

  prgb_scale u_scale_green (
    .clk(clk), .en(scale_en), .value(green1), .scale(scale_green),
    .invert(invert_mask[INV_GREEN]), .result(green3)
  );

  prgb_scale u_scale_blue (
    .clk(clk), .en(scale_en), .value(blue1), .scale(scale_blue),
    .invert(invert_mask[INV_BLUE]), .result(blue3)
  );

  prgb_scale u_scale_alpha (
    .clk(clk), .en(scale_en), .value(alpha1), .scale(scale_alpha),
    .invert(invert_mask[INV_ALPHA]), .result(alpha3)
  );

  // Stages 4 and 5: range expansion of the colour channels
  pair_en_t          expand_en;
  logic [CHAN_W-1:0] red5, green5, blue5, alpha5;

  assign expand_en = '{first: en[3], second: en[4]};

  prgb_expand u_expand_red (
    .clk(clk), .en(expand_en), .value(red3), .limited(limited_range),
    .result(red5)
  );

  prgb_expand u_expand_green (
    .clk(clk), .en(expand_en), .value(green3), .limited(limited_range),
    .result(green5)
  );

  prgb_expand u_expand_blue (
    .clk(clk), .en(expand_en), .value(blue3), .limited(limited_range),
    .result(blue5)
  );

  // Hold alpha and its fixed-value flag in step with the colour channels
  logic              fixed2, fixed3, fixed4;
  logic [CHAN_W-1:0] alpha4;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fixed2 <= fixed1;
    end
    if (en[2]) begin
      fixed3 <= fixed2;
    end
    if (en[3]) begin
      fixed4 <= fixed3;
      alpha4 <= alpha3;
    end
    if (en[4]) begin
      alpha5 <= fixed4 ? FULL_MAX : alpha4;
    end
  end

  // Gather the output stage into the result item
  always_comb begin
    out_data.red_out       = red5;
    out_data.green_out     = green5;
    out_data.blue_out      = blue5;
    out_data.alpha_out     = alpha5;
    out_data.frame_end_out = frame_end[STAGES-1];
  end

  // A stalled input means every stage holds an item
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> &valid)
    else $error("input stalled while a stage is empty");

  // An accepted item occupies the first stage next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> valid[0])
    else $error("accepted item lost at first stage");

  // Reset empties the output stage
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // RGB565 results carry full alpha
  assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_format != FMT_A2B10G10R10 |-> out_data.alpha_out == FULL_MAX)
    else $error("RGB565 alpha not full scale");

endmodule

### sim/tb_packed_rgb_to_rgba16_converter_unit.sv
// Self-checking testbench for the packed pixel to 16-bit RGBA converter.
`timescale 1ns / 1ps

module tb_packed_rgb_to_rgba16_converter_unit;
  import prgb_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 125;

  // Register settings as one unit, mirrored from what was written
  typedef struct packed {
    logic [1:0]         fmt;
    logic [SCALE_W-1:0] scale_r;
    logic [SCALE_W-1:0] scale_g;
    logic [SCALE_W-1:0] scale_b;
    logic [SCALE_W-1:0] scale_a;
    logic [3:0]         inv_mask;
    logic               lim;
  } conv_settings_t;

  typedef struct {
    conv_settings_t setting;
    pixel_in_t      px;
    bit             typed;
    pixel_out_t     want;
  } pixel_row_t;

  typedef struct {
    bit         typed;
    pixel_out_t want;
  } raised_pixel_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  pixel_in_t  in_data;
  logic       out_valid;
  logic       out_ready;
  pixel_out_t out_data;
  logic                  cfg_write;
  logic [2:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  conv_settings_t active_settings;
  pixel_row_t     directed_rows[$];
  raised_pixel_t  raised_pixels[$];
  pixel_out_t     expected_rgba[$];
  int             mismatch_count;
  int             cycle_count;
  int             stall_left;
  bit             tx_idling;
  bit             rx_idling;

  packed_rgb_to_rgba16_converter_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // Multiply, saturate to 16 bits, then optionally flip
  function automatic logic [CHAN_W-1:0] scale_clip_flip(logic [CHAN_W-1:0] v,
                                                        logic [SCALE_W-1:0] s,
                                                        logic flip);
    logic [CHAN_W+SCALE_W-1:0] prod;
    logic [CHAN_W-1:0]         c;
    prod = v * s;
    c = (prod > FULL_MAX) ? FULL_MAX : prod[CHAN_W-1:0];
    return flip ? (FULL_MAX - c) : c;
  endfunction

  // Stretch studio range to full range, floor division
  function automatic logic [CHAN_W-1:0] expand_limited(logic [CHAN_W-1:0] v);
    logic [31:0] span;
    if (v <= LIMITED_MIN) return '0;
    if (v >= LIMITED_MAX) return FULL_MAX;
    span = (32'(v) - 32'(LIMITED_MIN)) * 32'(FULL_MAX) /
           (32'(LIMITED_MAX) - 32'(LIMITED_MIN));
    return span[CHAN_W-1:0];
  endfunction

  function automatic pixel_out_t predict_rgba(pixel_in_t px);
    pixel_out_t        res;
    logic [15:0]       half;
    logic [1:0]        a2;
    logic [CHAN_W-1:0] r, g, b, a;
    if (active_settings.fmt == FMT_A2B10G10R10) begin
      r  = {px.pixel_word[9:0], 6'b0};
      g  = {px.pixel_word[19:10], 6'b0};
      b  = {px.pixel_word[29:20], 6'b0};
      a2 = px.pixel_word[31:30];
      a  = scale_clip_flip({8{a2}}, active_settings.scale_a,
                           active_settings.inv_mask[INV_ALPHA]);
    end else begin
      // Any nonzero code is 565; the swap bit selects big endian
      half = px.pixel_word[15:0];
      if (active_settings.fmt[FMT_SWAP_BIT]) half = {half[7:0], half[15:8]};
      r = 16'(32'(half[15:11]) * 32'(FULL_MAX) / 32'd31);
      g = 16'(32'(half[10:5]) * 32'(FULL_MAX) / 32'd63);
      b = 16'(32'(half[4:0]) * 32'(FULL_MAX) / 32'd31);
      a = FULL_MAX;
    end
    r = scale_clip_flip(r, active_settings.scale_r, active_settings.inv_mask[INV_RED]);
    g = scale_clip_flip(g, active_settings.scale_g, active_settings.inv_mask[INV_GREEN]);
    b = scale_clip_flip(b, active_settings.scale_b, active_settings.inv_mask[INV_BLUE]);
    if (active_settings.lim) begin
      r = expand_limited(r);
      g = expand_limited(g);
      b = expand_limited(b);
    end
    res.red_out       = r;
    res.green_out     = g;
    res.blue_out      = b;
    res.alpha_out     = a;
    res.frame_end_out = px.frame_end;
    return res;
  endfunction

  function automatic pixel_out_t rgba(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                      logic [15:0] a, logic fe);
    pixel_out_t res;
    res.red_out       = r;
    res.green_out     = g;
    res.blue_out      = b;
    res.alpha_out     = a;
    res.frame_end_out = fe;
    return res;
  endfunction

  function automatic conv_settings_t make_settings(logic [1:0] fmt, logic [9:0] sr,
                                                   logic [9:0] sg, logic [9:0] sb,
                                                   logic [9:0] sa, logic [3:0] inv,
                                                   logic lim);
    conv_settings_t s;
    s.fmt      = fmt;
    s.scale_r  = sr;
    s.scale_g  = sg;
    s.scale_b  = sb;
    s.scale_a  = sa;
    s.inv_mask = inv;
    s.lim      = lim;
    return s;
  endfunction

  // Favor small scales so that values do not always saturate
  function automatic logic [SCALE_W-1:0] rand_scale();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 10'd1;
      2: return SCALE_W'($urandom_range(2, 8));
      3: return SCALE_W'($urandom_range(0, 1023));
      default: return 10'd1023;
    endcase
  endfunction

  function automatic conv_settings_t rand_settings();
    return make_settings(2'($urandom_range(0, 3)), rand_scale(), rand_scale(),
                         rand_scale(), rand_scale(), 4'($urandom_range(0, 15)),
                         1'($urandom_range(0, 1)));
  endfunction

  function automatic pixel_in_t rand_pixel();
    pixel_in_t px;
    case ($urandom_range(0, 7))
      0: px.pixel_word = 32'hFFFF_FFFF ^ (32'd1 << $urandom_range(0, 31));
      1: px.pixel_word = 32'd1 << $urandom_range(0, 31);
      default: px.pixel_word = $urandom;
    endcase
    px.frame_end = ($urandom_range(0, 7) == 0);
    return px;
  endfunction

  task automatic add_row(conv_settings_t s, logic [31:0] word, logic fe, bit typed,
                         pixel_out_t want);
    pixel_row_t row;
    row.setting      = s;
    row.px.pixel_word = word;
    row.px.frame_end  = fe;
    row.typed        = typed;
    row.want         = want;
    directed_rows.push_back(row);
  endtask

  task automatic check_field(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Hold off the sender until every result is back, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_rgba.size() != 0 || raised_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(conv_settings_t s);
    wait_drained();
    write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(s.fmt));
    write_reg(REG_SCALE_RED, s.scale_r);
    write_reg(REG_SCALE_GREEN, s.scale_g);
    write_reg(REG_SCALE_BLUE, s.scale_b);
    write_reg(REG_SCALE_ALPHA, s.scale_a);
    write_reg(REG_INVERT_MASK, CFG_DATA_W'(s.inv_mask));
    write_reg(REG_LIMITED_RANGE, CFG_DATA_W'(s.lim));
    cfg_write <= 1'b0;
    active_settings = s;
  endtask

  // Offer one item, with an optional gap ahead of it, and hold until taken
  task automatic send_pixel(pixel_in_t px, bit typed, pixel_out_t want);
    raised_pixel_t rp;
    if (tx_idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    rp.typed = typed;
    rp.want  = want;
    raised_pixels.push_back(rp);
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  // Check results, record accepted items, and drive receiver stalls
  always @(posedge clk) begin : result_check
    pixel_out_t    want;
    raised_pixel_t rp;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rgba.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result with no item pending, expected none, got %p",
                   $time, out_data);
        end else begin
          want = expected_rgba.pop_front();
          check_field("red_out", want.red_out, out_data.red_out);
          check_field("green_out", want.green_out, out_data.green_out);
          check_field("blue_out", want.blue_out, out_data.blue_out);
          check_field("alpha_out", want.alpha_out, out_data.alpha_out);
          check_field("frame_end_out", CHAN_W'(want.frame_end_out),
                      CHAN_W'(out_data.frame_end_out));
        end
      end
      if (in_valid && in_ready) begin
        rp = raised_pixels.pop_front();
        expected_rgba.push_back(rp.typed ? rp.want : predict_rgba(in_data));
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_packed_rgb_to_rgba16_converter_unit: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    conv_settings_t s_reset, s_le, s_be, s_fmt3, s_zero_inv, s_max, s_lim, s_le_inv;
    conv_settings_t s;
    pixel_out_t     none;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    in_data        <= '0;
    cfg_write      <= 1'b0;
    cfg_index      <= REG_PIXEL_FORMAT;
    cfg_data       <= '0;
    mismatch_count = 0;
    cycle_count    = 0;
    stall_left     = 0;
    tx_idling      = 1'b1;
    rx_idling      = 1'b1;
    none           = '0;
    s_reset    = make_settings(FMT_A2B10G10R10, 1, 1, 1, 1, 4'h0, 1'b0);
    s_le       = make_settings(FMT_RGB565_LE, 1, 1, 1, 1, 4'h0, 1'b0);
    s_be       = make_settings(FMT_RGB565_BE, 1, 1, 1, 1, 4'h0, 1'b0);
    s_fmt3     = make_settings(2'd3, 1, 1, 1, 1, 4'h0, 1'b0);
    s_zero_inv = make_settings(FMT_A2B10G10R10, 0, 0, 0, 0, 4'hF, 1'b0);
    s_max      = make_settings(FMT_A2B10G10R10, 1023, 1023, 1023, 1023, 4'h0, 1'b0);
    s_lim      = make_settings(FMT_A2B10G10R10, 1, 1, 1, 1, 4'h0, 1'b1);
    s_le_inv   = make_settings(FMT_RGB565_LE, 1, 1, 1, 0, 4'hF, 1'b0);
    active_settings = s_reset;

    // Directed items: field extremes, every format, and the corner settings
    add_row(s_reset, 32'h0000_0000, 1'b0, 1, rgba(16'h0, 16'h0, 16'h0, 16'h0, 1'b0));
    add_row(s_reset, 32'hFFFF_FFFF, 1'b1, 1,
            rgba(16'hFFC0, 16'hFFC0, 16'hFFC0, 16'hFFFF, 1'b1));
    add_row(s_reset, 32'h4000_0000, 1'b0, 1, rgba(16'h0, 16'h0, 16'h0, 16'h5555, 1'b0));
    add_row(s_reset, 32'h8000_0000, 1'b1, 1, rgba(16'h0, 16'h0, 16'h0, 16'hAAAA, 1'b1));
    add_row(s_reset, 32'h0000_03FF, 1'b0, 1, rgba(16'hFFC0, 16'h0, 16'h0, 16'h0, 1'b0));
    add_row(s_reset, 32'h000F_FC00, 1'b0, 1, rgba(16'h0, 16'hFFC0, 16'h0, 16'h0, 1'b0));
    add_row(s_reset, 32'h3FF0_0000, 1'b0, 1, rgba(16'h0, 16'h0, 16'hFFC0, 16'h0, 1'b0));
    add_row(s_le, 32'h0000_FFFF, 1'b0, 1,
            rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    add_row(s_le, 32'hFFFF_0000, 1'b1, 1, rgba(16'h0, 16'h0, 16'h0, 16'hFFFF, 1'b1));
    add_row(s_le, 32'h0000_F800, 1'b0, 1, rgba(16'hFFFF, 16'h0, 16'h0, 16'hFFFF, 1'b0));
    add_row(s_le, 32'h0000_07E0, 1'b0, 1, rgba(16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 1'b0));
    add_row(s_le, 32'h0000_001F, 1'b0, 1, rgba(16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 1'b0));
    add_row(s_le, 32'h0000_0841, 1'b0, 0, none);
    add_row(s_be, 32'h0000_00F8, 1'b0, 1, rgba(16'hFFFF, 16'h0, 16'h0, 16'hFFFF, 1'b0));
    add_row(s_be, 32'h0000_E007, 1'b0, 1, rgba(16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 1'b0));
    add_row(s_be, 32'h0000_1F00, 1'b1, 1, rgba(16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 1'b1));
    // Unused format code decodes as big endian 565
    add_row(s_fmt3, 32'h0000_00F8, 1'b0, 1, rgba(16'hFFFF, 16'h0, 16'h0, 16'hFFFF, 1'b0));
    // Zero scale gives zero, then the full inversion
    add_row(s_zero_inv, 32'hFFFF_FFFF, 1'b1, 1,
            rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    add_row(s_zero_inv, 32'h0000_0000, 1'b0, 1,
            rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    add_row(s_max, 32'hFFFF_FFFF, 1'b0, 1,
            rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    add_row(s_max, 32'h0010_0401, 1'b0, 0, none);
    // Range expansion at both limited bounds and just above the lower one
    add_row(s_lim, 32'h0000_0040, 1'b0, 1, rgba(16'h0, 16'h0, 16'h0, 16'h0, 1'b0));
    add_row(s_lim, 32'h0000_03AC, 1'b0, 1, rgba(16'hFFFF, 16'h0, 16'h0, 16'h0, 1'b0));
    add_row(s_lim, 32'h0000_0041, 1'b0, 0, none);
    // In 565 mode alpha ignores its scale and inversion
    add_row(s_le_inv, 32'h0000_0000, 1'b0, 1,
            rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table, rewriting registers where a row needs it
    foreach (directed_rows[i]) begin
      if (directed_rows[i].setting != active_settings)
        apply_settings(directed_rows[i].setting);
      send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases, each with fresh settings; no idling in the last two
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      s = rand_settings();
      apply_settings(s);
      tx_idling = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      rx_idling = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == PHASE_ITEMS / 2) wait_drained();
        send_pixel(rand_pixel(), 1'b0, none);
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("tb_packed_rgb_to_rgba16_converter_unit: PASS");
    end else begin
      $display("tb_packed_rgb_to_rgba16_converter_unit: FAIL");
    end
    $finish;
  end

endmodule

### packed_rgb_to_rgba16_converter_unit.f
hdl/prgb_pkg.sv
hdl/prgb_unpack.sv
hdl/prgb_scale.sv
hdl/prgb_expand.sv
hdl/packed_rgb_to_rgba16_converter_unit.sv
sim/tb_packed_rgb_to_rgba16_converter_unit.sv
